/* src/sstq_pkg.sv */
// Shared types and constants for the sorted sleep timer queue.
`timescale 1ns / 1ps
`default_nettype none

package sstq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int MAX_RESULTS   = 16;

  localparam int TIME_W = 64;
  localparam int ID_W   = 8;
  localparam int PRIO_W = 6;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_QUEUED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NO_WAKE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic due;      // entry wake time at or before the key
    logic preempt;  // entry priority above the running priority
  } cmp_flags_t;

endpackage

`default_nettype wire

/* src/sstq_store.sv */
// Sleeper table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sstq_store #(
  parameter int QUEUE_DEPTH = sstq_pkg::DEFAULT_DEPTH
) (
  input  wire                           clk,
  input  wire                           we,
  input  wire [$clog2(QUEUE_DEPTH)-1:0] waddr,
  input  sstq_pkg::entry_t              wdata,
  input  wire [$clog2(QUEUE_DEPTH)-1:0] raddr,
  output sstq_pkg::entry_t              rdata
);
  import sstq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sstq_cmp.sv */
// Shared compare unit: wake time against the key, priority against the runner.
`timescale 1ns / 1ps
`default_nettype none

module sstq_cmp (
  input  sstq_pkg::entry_t                ent,
  input  wire [sstq_pkg::TIME_W-1:0]      key,
  input  wire [sstq_pkg::PRIO_W-1:0]      run_prio,
  output sstq_pkg::cmp_flags_t            flags
);
  import sstq_pkg::*;

  always_comb begin
    flags.due     = (ent.wake <= key);
    flags.preempt = (ent.prio > run_prio);
  end

endmodule

`default_nettype wire

/* src/sorted_sleep_timer_queue.sv */
// Top level of the sorted sleep timer queue: sequencer, counters and result register.
//
// Usage: pulse start with the request fields while busy is low; the item is
// taken at that edge. req_type 0 is a sleep request, 1 is a timer tick.
// Results appear on result_kind, woken_thread, preempt and last for exactly
// one cycle each, marked by result_strobe; last marks the final one.
// The table is a circular buffer in one memory, sorted by wake time from the
// head; the sequencer walks it one entry per cycle through the single read
// port and one shared compare unit.
// Sleep request: the sequencer compares the queued entries from the tail and
// moves each one that wakes strictly later up one slot, then writes the new
// entry into the freed slot; on an empty table it goes straight to the write.
// A request on a full table is rejected in the cycle right after accept.
// Tick: due entries pop from the head, each shown once the next has been
// compared, one per cycle; at most 16 wake per tick. A tick with no due entry
// gives its result from the pop state. busy drops in the cycle the final result
// shows, so the next item can be taken while that result is on the ports.
// Reset clears the tick counter and empties the table; no clearing pass.
// The receiver cannot stall: every result is taken in the cycle it shows.
`timescale 1ns / 1ps
`default_nettype none

module sorted_sleep_timer_queue #(
  parameter int QUEUE_DEPTH = sstq_pkg::DEFAULT_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire                          req_type,
  input  wire [sstq_pkg::ID_W-1:0]     sleeper_thread,
  input  wire [31:0]                   sleep_ticks,
  input  wire [sstq_pkg::PRIO_W-1:0]   sleeper_prio,
  input  wire [sstq_pkg::PRIO_W-1:0]   running_prio,
  output logic                         result_strobe,
  output logic [sstq_pkg::KIND_W-1:0]  result_kind,
  output logic [sstq_pkg::ID_W-1:0]    woken_thread,
  output logic                         preempt,
  output logic                         last
);
  import sstq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [NW-1:0] MAX_N   = NW'(MAX_RESULTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;
  localparam logic [1:0] ST_POP  = 2'd3;

  logic [1:0]        state;
  logic [TIME_W-1:0] tick_count;
  logic [TIME_W-1:0] key;
  logic [ID_W-1:0]   new_id;
  logic [PRIO_W-1:0] new_prio;
  logic [PRIO_W-1:0] run_prio;
  logic [AW-1:0]     head;
  logic [CW-1:0]     occ;
  logic [AW-1:0]     cnt;
  logic [NW-1:0]     n;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;
  logic              pend_pre;

  logic [TIME_W-1:0] sum;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  entry_t            wdata;
  entry_t            rdata;
  cmp_flags_t        flags;

  // Logical slot to memory address, wrapping once past the end.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] j);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, j};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  sstq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sstq_cmp u_cmp (
    .ent      (rdata),
    .key      (key),
    .run_prio (run_prio),
    .flags    (flags)
  );

  assign busy = (state != ST_IDLE);
  assign sum  = tick_count + (req_type ? TIME_W'(1) : TIME_W'(sleep_ticks));

  always_comb begin
    we    = 1'b0;
    waddr = phys(head, cnt);
    wdata = rdata;
    raddr = phys(head, '0);
    case (state)
      ST_IDLE: begin
        if (!req_type) begin
          raddr = phys(head, AW'(occ - CW'(1)));
        end
      end
      ST_CMP: begin
        raddr = phys(head, cnt - AW'(2));
        // Later wake time: move the entry up one slot.
        we    = !flags.due;
      end
      ST_INS: begin
        we    = 1'b1;
        wdata = '{wake: key, id: new_id, prio: new_prio};
      end
      ST_POP: begin
        raddr = phys(head, AW'(1));
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tick_count    <= '0;
      head          <= '0;
      occ           <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            key <= sum;
            if (req_type) begin
              tick_count <= sum;
              run_prio   <= running_prio;
              n          <= '0;
              pend_valid <= 1'b0;
              state      <= ST_POP;
            end else if (occ == DEPTH_C) begin
              result_strobe <= 1'b1;
              result_kind   <= KIND_REJECTED;
              woken_thread  <= '0;
              preempt       <= 1'b0;
              last          <= 1'b1;
            end else begin
              new_id   <= sleeper_thread;
              new_prio <= sleeper_prio;
              cnt      <= AW'(occ);
              state    <= (occ == '0) ? ST_INS : ST_CMP;
            end
          end
        end
        ST_CMP: begin
          if (!flags.due) begin
            cnt <= cnt - AW'(1);
            if (cnt == AW'(1)) begin
              state <= ST_INS;
            end
          end else begin
            state <= ST_INS;
          end
        end
        ST_INS: begin
          occ           <= occ + CW'(1);
          result_strobe <= 1'b1;
          result_kind   <= KIND_QUEUED;
          woken_thread  <= '0;
          preempt       <= 1'b0;
          last          <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_POP: begin
          if (occ != '0 && n != MAX_N && flags.due) begin
            // Pop the head; hold it until the next entry shows whether it is last.
            head       <= phys(head, AW'(1));
            occ        <= occ - CW'(1);
            n          <= n + NW'(1);
            pend_valid <= 1'b1;
            pend_id    <= rdata.id;
            pend_pre   <= flags.preempt;
            if (pend_valid) begin
              result_strobe <= 1'b1;
              result_kind   <= KIND_WOKEN;
              woken_thread  <= pend_id;
              preempt       <= pend_pre;
              last          <= 1'b0;
            end
          end else begin
            result_strobe <= 1'b1;
            last          <= 1'b1;
            if (pend_valid) begin
              result_kind  <= KIND_WOKEN;
              woken_thread <= pend_id;
              preempt      <= pend_pre;
            end else begin
              result_kind  <= KIND_NO_WAKE;
              woken_thread <= '0;
              preempt      <= 1'b0;
            end
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= DEPTH_C)
    else $error("occupancy above table depth");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result_kind == KIND_REJECTED |-> occ == DEPTH_C)
    else $error("sleep rejected while table not full");

  a_queued_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result_kind == KIND_QUEUED |-> occ != '0)
    else $error("sleep queued but table empty");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> result_strobe && result_kind == KIND_WOKEN)
    else $error("wake burst broken before last result");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |-> !busy)
    else $error("final result shown while still busy");

endmodule

`default_nettype wire

/* verif/tb_sorted_sleep_timer_queue.sv */
// Self-checking testbench for the sorted sleep timer queue.
`timescale 1ns / 1ps

module tb_sorted_sleep_timer_queue;
  import sstq_pkg::*;

  localparam int DEPTH      = DEFAULT_DEPTH;
  localparam int TAIL_ITEMS = 25;
  localparam int DRAIN_CYC  = 40;
  localparam int LIMIT_CYC  = 200000;
  localparam int MAX_PRINTS = 100;

  typedef struct {
    bit                tick;
    logic [ID_W-1:0]   thread;
    logic [31:0]       ticks;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] run_prio;
  } alarm_req_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   thread;
    logic              preempt;
    logic              last;
  } wake_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = 1'b0;
  logic [ID_W-1:0] sleeper_thread = '0;
  logic [31:0] sleep_ticks = '0;
  logic [PRIO_W-1:0] sleeper_prio = '0;
  logic [PRIO_W-1:0] running_prio = '0;
  logic busy;
  logic result_strobe;
  logic [KIND_W-1:0] result_kind;
  logic [ID_W-1:0] woken_thread;
  logic preempt;
  logic last;

  sorted_sleep_timer_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .sleeper_thread(sleeper_thread),
    .sleep_ticks(sleep_ticks),
    .sleeper_prio(sleeper_prio),
    .running_prio(running_prio),
    .result_strobe(result_strobe),
    .result_kind(result_kind),
    .woken_thread(woken_thread),
    .preempt(preempt),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the sleeper table, sorted by wake time from slot 0.
  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] slot_wake [DEPTH];
  logic [ID_W-1:0]   slot_id   [DEPTH];
  logic [PRIO_W-1:0] slot_prio [DEPTH];
  int                fill;

  alarm_req_t   request_fifo [$];
  wake_report_t due_reports [$];
  alarm_req_t   on_port;
  int           total_items;
  int           accepted;
  int           errors;
  int           gap_left;
  int           calm_left;
  int           cycles;

  task automatic alarm_step(input alarm_req_t r);
    logic [TIME_W-1:0] wt;
    int pos;
    int n;
    wake_report_t rep;
    if (!r.tick) begin
      rep = '{kind: KIND_QUEUED, thread: '0, preempt: 1'b0, last: 1'b1};
      if (fill >= DEPTH) begin
        rep.kind = KIND_REJECTED;
      end else begin
        wt = now_ticks + {32'd0, r.ticks};
        pos = 0;
        while (pos < fill && slot_wake[pos] <= wt) pos++;
        for (int i = fill; i > pos; i--) begin
          slot_wake[i] = slot_wake[i-1];
          slot_id[i]   = slot_id[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_wake[pos] = wt;
        slot_id[pos]   = r.thread;
        slot_prio[pos] = r.prio;
        fill++;
      end
      due_reports.push_back(rep);
    end else begin
      now_ticks = now_ticks + 1;
      n = 0;
      while (n < fill && n < MAX_RESULTS && slot_wake[n] <= now_ticks) n++;
      if (n == 0) begin
        due_reports.push_back('{kind: KIND_NO_WAKE, thread: '0, preempt: 1'b0, last: 1'b1});
      end else begin
        for (int i = 0; i < n; i++) begin
          rep.kind    = KIND_WOKEN;
          rep.thread  = slot_id[i];
          rep.preempt = slot_prio[i] > r.run_prio;
          rep.last    = (i == n - 1);
          due_reports.push_back(rep);
        end
        for (int i = n; i < fill; i++) begin
          slot_wake[i-n] = slot_wake[i];
          slot_id[i-n]   = slot_id[i];
          slot_prio[i-n] = slot_prio[i];
        end
        fill -= n;
      end
    end
  endtask

  // Unused fields carry random content so they are seen to be ignored.
  task automatic add_sleep(input logic [ID_W-1:0] id, input logic [31:0] dur,
                           input logic [PRIO_W-1:0] prio);
    request_fifo.push_back('{tick: 1'b0, thread: id, ticks: dur, prio: prio,
                             run_prio: PRIO_W'($urandom_range(0, 63))});
  endtask

  task automatic add_tick(input logic [PRIO_W-1:0] run);
    request_fifo.push_back('{tick: 1'b1, thread: ID_W'($urandom_range(0, 255)),
                             ticks: $urandom, prio: PRIO_W'($urandom_range(0, 63)),
                             run_prio: run});
  endtask

  // Driver: present the next item, hold it while busy, idle in bursts.
  always @(posedge clk) begin : drive
    bit taken;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        alarm_step(on_port);
        accepted++;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 9) == 0) begin
          calm_left = $urandom_range(5, 20);
        end else if (request_fifo.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0) begin
          gap_left = $urandom_range(1, 10);
        end
      end
      if (!start || taken) begin
        if (gap_left > 0 || request_fifo.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          on_port = request_fifo.pop_front();
          start          <= 1'b1;
          req_type       <= on_port.tick;
          sleeper_thread <= on_port.thread;
          sleep_ticks    <= on_port.ticks;
          sleeper_prio   <= on_port.prio;
          running_prio   <= on_port.run_prio;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest owed report.
  always @(posedge clk) begin : check
    wake_report_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (due_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: unexpected result: kind %0d thread %0d preempt %0d last %0d",
                   $time, result_kind, woken_thread, preempt, last);
      end else begin
        want = due_reports.pop_front();
        if (result_kind !== want.kind || woken_thread !== want.thread ||
            preempt !== want.preempt || last !== want.last) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: mismatch: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                     $time, want.kind, want.thread, want.preempt, want.last,
                     result_kind, woken_thread, preempt, last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == LIMIT_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int burst;
    now_ticks = '0;
    fill = 0;
    accepted = 0;
    errors = 0;
    gap_left = 0;
    calm_left = 0;
    cycles = 0;

    // Fill the table with sleepers due on the first tick, overflow it once,
    // then wake all of them with a single tick.
    for (int i = 0; i < DEPTH; i++)
      add_sleep((i == 0) ? 8'd0 : (i == 1) ? 8'hFF : ID_W'($urandom_range(1, 254)),
                32'd0, (i % 2 == 0) ? 6'd63 : (i % 3 == 0) ? 6'd0 : PRIO_W'($urandom));
    add_sleep(8'h7F, 32'd5, 6'd20);
    add_tick(6'd31);
    add_tick(6'd63);
    // Far-off sleepers stay for the whole run and sit behind everything else.
    add_sleep(8'h01, 32'hFFFF_FFFF, 6'd63);
    add_sleep(8'h02, 32'h8000_0000, 6'd0);
    // Equal wake times keep arrival order; shorter sleeps insert ahead.
    add_sleep(8'h03, 32'd2, 6'd40);
    add_sleep(8'h04, 32'd2, 6'd20);
    add_sleep(8'h05, 32'd1, 6'd10);
    add_sleep(8'h06, 32'd0, 6'd63);
    add_tick(6'd0);
    add_tick(6'd63);
    add_tick(6'd0);

    // Random part: mostly bursts of near-term sleeps followed by ticks.
    while (request_fifo.size() < 172) begin
      if ($urandom_range(0, 9) < 7) begin
        burst = $urandom_range(1, 8);
        for (int i = 0; i < burst; i++)
          add_sleep(ID_W'($urandom_range(0, 255)),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 6),
                    PRIO_W'($urandom_range(0, 63)));
        burst = $urandom_range(1, 8);
        for (int i = 0; i < burst; i++)
          add_tick(PRIO_W'($urandom_range(0, 63)));
      end else if ($urandom_range(0, 1) == 0) begin
        add_sleep(ID_W'($urandom_range(0, 255)), $urandom_range(0, 10),
                  PRIO_W'($urandom_range(0, 63)));
      end else begin
        add_tick(PRIO_W'($urandom_range(0, 63)));
      end
    end
    total_items = request_fifo.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted != total_items || due_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
